// ===== rtl/frustum_grid_triangle_culler_assert.svh =====
// Assertion macros for the frustum grid triangle culler RTL
`ifndef FRUSTUM_GRID_TRIANGLE_CULLER_ASSERT_SVH
`define FRUSTUM_GRID_TRIANGLE_CULLER_ASSERT_SVH

// check in the same cycle
`define FGTC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check in the next cycle
`define FGTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fgtc_pkg.sv =====
// Types and constants of the frustum grid triangle culler
`timescale 1ns / 1ps
`default_nettype none

package fgtc_pkg;

   localparam int MAX_COLUMNS  = 256;
   localparam int COL_W        = $clog2(MAX_COLUMNS);
   localparam int COLS_W       = COL_W + 1;
   localparam int PLANE_COUNT  = 6;
   localparam int AXES         = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int COORD_W      = 16;
   localparam int RAD_W        = 15;
   localparam int FRAC_SHIFT   = 14;
   localparam int PROD_W       = 2 * COORD_W;
   localparam int DOFF_W       = COORD_W + FRAC_SHIFT;
   localparam int DIST_W       = PROD_W + 2;
   localparam int LIM_PAD      = DIST_W - RAD_W - FRAC_SHIFT;
   localparam int VERT_W       = 16;
   localparam int SLOT_W       = 17;
   localparam int PIPE_DEPTH   = 5;
   localparam int LOOKUP_STAGE = 3;
   localparam int EMIT_STAGE   = 4;

   localparam logic [VERT_W-1:0] VERTEX_MAX         = '1;
   localparam logic [SLOT_W-1:0] TRI_MAX            = '1;
   localparam logic [COLS_W-1:0] GRID_COLUMNS_RESET = COLS_W'(129);
   localparam logic [COLS_W-1:0] COLS_MIN           = COLS_W'(2);
   localparam logic [COLS_W-1:0] COLS_MAX           = COLS_W'(MAX_COLUMNS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLANE_TOP    = 3'd0,
      CSR_PLANE_BOTTOM = 3'd1,
      CSR_PLANE_RIGHT  = 3'd2,
      CSR_PLANE_LEFT   = 3'd3,
      CSR_PLANE_FAR    = 3'd4,
      CSR_PLANE_NEAR   = 3'd5,
      CSR_GRID_COLUMNS = 3'd6
   } csr_index_type;

   typedef enum logic {
      MODE_GRID   = 1'b0,
      MODE_SPHERE = 1'b1
   } mode_type;

   typedef enum logic {
      KIND_SPHERE   = 1'b0,
      KIND_TRIANGLE = 1'b1
   } kind_type;

   typedef struct packed {
      mode_type                   mode;
      logic                       restart;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
      logic [RAD_W-1:0]           radius;
   } req_type;

   typedef struct packed {
      kind_type                   result_kind;
      logic                       inside_res;
      logic [SLOT_W-1:0]          tri_slot;
      logic [VERT_W-1:0]          corner_a;
      logic [VERT_W-1:0]          corner_b;
      logic [VERT_W-1:0]          corner_c;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      mode_type                   mode;
      logic                       restart;
      logic [COL_W-1:0]           col;
      logic                       last_col;
      logic                       row_nz;
      logic [VERT_W-1:0]          v_idx;
      logic [VERT_W-1:0]          p_idx;
      logic [VERT_W-1:0]          u_idx;
      logic [VERT_W-1:0]          q_idx;
   } ctrl_type;

   typedef struct packed {
      logic                       en;
      logic [COL_W-1:0]           addr;
      logic                       data;
   } wr_type;

endpackage

`default_nettype wire

// ===== rtl/frustum_grid_triangle_culler.sv =====
// Frustum grid triangle culler: six-plane point test and grid triangle emission
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_grid_triangle_culler_assert.svh"

// Requests pass a five-stage pipeline (input register, 18 plane products, plane
// sums, plane compares, emit stage) and results leave through an output register.
// The emit stage sets the rate: a sphere query or a grid vertex that yields at most
// one triangle leaves it in a single phase; a vertex that yields two triangles, or
// closes a grid row, takes a second phase, since one result leaves per cycle while
// the output does not stall and the row memory takes one write per cycle. The
// previous row's inside bits live in two mirrored 256 x 1 RAMs read at the up and
// diagonal columns; per-entry valid flags make them read as zero after reset, so
// no clearing pass is needed and requests are taken right away.
module frustum_grid_triangle_culler
   import fgtc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CSR_DATA_W-1:0] plane_ff [PLANE_COUNT];
   logic [COLS_W-1:0]     grid_columns_ff;

   logic [COL_W-1:0]      col_ff;
   logic                  row_nz_ff;
   logic [VERT_W-1:0]     vnum_ff;

   logic                  stage_valid_ff [PIPE_DEPTH];
   ctrl_type              ctrl_ff [PIPE_DEPTH];
   req_type               req0_ff;
   logic signed [PROD_W-1:0] prod_ff [PLANE_COUNT][AXES];
   logic signed [DOFF_W-1:0] doff_ff [PLANE_COUNT];
   logic [RAD_W-1:0]      rad1_ff;
   logic signed [DIST_W-1:0] dist_ff [PLANE_COUNT];
   logic signed [DIST_W-1:0] limit_ff;
   logic                  inside3_ff;
   logic                  inside4_ff;

   logic                  row_valid_ff [MAX_COLUMNS];
   logic                  vld_up_ff;
   logic                  vld_dg_ff;
   wr_type                lw_ff;

   logic                  phase_ff;
   logic                  both_ff;
   logic                  left_ff;
   logic [SLOT_W-1:0]     tc_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_payload_ff;

   logic                  adv;
   logic                  accept;
   logic [COLS_W-1:0]     cols;
   logic [COL_W-1:0]      col_base;
   logic [COL_W-1:0]      col_sel;
   logic                  row_nz_base;
   logic [VERT_W-1:0]     v_base;
   logic                  last_col;
   ctrl_type              ctrl_in;
   logic                  inside_calc;

   logic [COL_W-1:0]      up_rd_addr;
   logic [COL_W-1:0]      dg_rd_addr;
   logic                  up_q;
   logic                  dg_q;

   ctrl_type              c4;
   logic                  grid4;
   logic [COL_W-1:0]      dg_addr4;
   logic                  left_eff;
   logic                  up_bit;
   logic                  dg_bit;
   logic                  tri_ok;
   logic                  t1;
   logic                  t2;
   logic                  both;
   logic                  needs2;
   logic [SLOT_W-1:0]     tc_cur;
   logic                  emit_req;
   logic                  out_free;
   logic                  step;
   logic                  emit;
   logic                  retire;
   rsp_type               rsp_next;
   wr_type                wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
         grid_columns_ff <= GRID_COLUMNS_RESET;
      end else if (csr_wen) begin
         if (csr_index < CSR_INDEX_W'(PLANE_COUNT)) begin
            plane_ff[csr_index] <= csr_wdata;
         end else if (csr_index == CSR_GRID_COLUMNS) begin
            grid_columns_ff <= csr_wdata[COLS_W-1:0];
         end
      end
   end

   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_comb begin
      cols = grid_columns_ff;
      if (grid_columns_ff < COLS_MIN) begin
         cols = COLS_MIN;
      end else if (grid_columns_ff > COLS_MAX) begin
         cols = COLS_MAX;
      end
      col_base    = req_payload.restart ? '0 : col_ff;
      row_nz_base = !req_payload.restart && row_nz_ff;
      v_base      = req_payload.restart ? '0 : vnum_ff;
      col_sel     = col_base;
      if ({1'b0, col_base} >= cols) begin
         col_sel = COL_W'(cols - COLS_W'(1));
      end
      last_col = ({1'b0, col_sel} == (cols - COLS_W'(1)));

      ctrl_in.mode     = req_payload.mode;
      ctrl_in.restart  = req_payload.restart;
      ctrl_in.col      = col_sel;
      ctrl_in.last_col = last_col;
      ctrl_in.row_nz   = row_nz_base;
      ctrl_in.v_idx    = v_base;
      ctrl_in.p_idx    = v_base - VERT_W'(1);
      ctrl_in.u_idx    = v_base - VERT_W'(cols);
      ctrl_in.q_idx    = v_base - VERT_W'(cols) - VERT_W'(1);
   end

   // advance the grid position at request time
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_nz_ff <= 1'b0;
         vnum_ff   <= '0;
      end else if (accept && (req_payload.mode == MODE_GRID)) begin
         col_ff    <= last_col ? '0 : col_sel + COL_W'(1);
         row_nz_ff <= row_nz_base || last_col;
         vnum_ff   <= (v_base == VERTEX_MAX) ? v_base : v_base + VERT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_DEPTH; s++) begin
            stage_valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         stage_valid_ff[0] <= accept;
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            stage_valid_ff[s] <= stage_valid_ff[s-1];
         end
      end
   end

   always_comb begin
      inside_calc = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         if (dist_ff[p] > limit_ff) begin
            inside_calc = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req0_ff    <= req_payload;
         ctrl_ff[0] <= ctrl_in;
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            ctrl_ff[s] <= ctrl_ff[s-1];
         end
         for (int p = 0; p < PLANE_COUNT; p++) begin
            prod_ff[p][0] <= $signed(plane_ff[p][15:0]) * req0_ff.pos_x;
            prod_ff[p][1] <= $signed(plane_ff[p][31:16]) * req0_ff.pos_y;
            prod_ff[p][2] <= $signed(plane_ff[p][47:32]) * req0_ff.pos_z;
            doff_ff[p]    <= {plane_ff[p][63:48], {FRAC_SHIFT{1'b0}}};
            dist_ff[p]    <= DIST_W'(prod_ff[p][0]) + DIST_W'(prod_ff[p][1])
                           + DIST_W'(prod_ff[p][2]) + DIST_W'(doff_ff[p]);
         end
         rad1_ff    <= (req0_ff.mode == MODE_SPHERE) ? req0_ff.radius : '0;
         limit_ff   <= {{LIM_PAD{1'b0}}, rad1_ff, {FRAC_SHIFT{1'b0}}};
         inside3_ff <= inside_calc;
         inside4_ff <= inside3_ff;
      end
   end

   assign up_rd_addr = ctrl_ff[LOOKUP_STAGE].col;
   assign dg_rd_addr = ctrl_ff[LOOKUP_STAGE].col - COL_W'(1);

   fgtc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_COLUMNS)
   ) u_up_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (adv),
      .rd_addr (up_rd_addr),
      .rd_data (up_q)
   );

   fgtc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_COLUMNS)
   ) u_dg_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (adv),
      .rd_addr (dg_rd_addr),
      .rd_data (dg_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            row_valid_ff[i] <= 1'b0;
         end
         lw_ff <= '0;
      end else if (wr.en) begin
         row_valid_ff[wr.addr] <= 1'b1;
         lw_ff                 <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vld_up_ff <= row_valid_ff[up_rd_addr];
         vld_dg_ff <= row_valid_ff[dg_rd_addr];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      c4       = ctrl_ff[EMIT_STAGE];
      grid4    = (c4.mode == MODE_GRID);
      dg_addr4 = c4.col - COL_W'(1);
      left_eff = !c4.restart && left_ff;
      // forward the latest row write over the RAM read
      up_bit   = (lw_ff.en && (lw_ff.addr == c4.col)) ? lw_ff.data : (up_q && vld_up_ff);
      dg_bit   = (lw_ff.en && (lw_ff.addr == dg_addr4)) ? lw_ff.data : (dg_q && vld_dg_ff);
      tri_ok   = grid4 && (c4.col != '0) && c4.row_nz;
      t1       = tri_ok && (left_eff || inside4_ff || up_bit);
      t2       = tri_ok && (left_eff || up_bit || dg_bit);
      both     = t1 && t2;
      needs2   = grid4 && (both || c4.last_col);
      tc_cur   = (!phase_ff && c4.restart) ? '0 : tc_ff;

      rsp_next.result_kind = KIND_TRIANGLE;
      rsp_next.inside_res  = 1'b0;
      rsp_next.tri_slot    = tc_cur;
      rsp_next.corner_a    = c4.p_idx;
      rsp_next.corner_b    = c4.u_idx;
      rsp_next.corner_c    = c4.q_idx;
      rsp_next.last        = 1'b1;

      if (!grid4) begin
         emit_req             = 1'b1;
         rsp_next.result_kind = KIND_SPHERE;
         rsp_next.inside_res  = inside4_ff;
         rsp_next.tri_slot    = '0;
         rsp_next.corner_a    = '0;
         rsp_next.corner_b    = '0;
         rsp_next.corner_c    = '0;
      end else if (!phase_ff) begin
         emit_req      = t1 || t2;
         rsp_next.last = !both;
         if (t1) begin
            rsp_next.corner_b = c4.v_idx;
            rsp_next.corner_c = c4.u_idx;
         end
      end else begin
         emit_req = both_ff;
      end

      step   = stage_valid_ff[EMIT_STAGE] && (!emit_req || out_free);
      emit   = step && emit_req;
      retire = step && (phase_ff || !needs2);
      adv    = !stage_valid_ff[EMIT_STAGE] || retire;

      wr = '0;
      if (step && !phase_ff && grid4 && (c4.col != '0)) begin
         wr.en   = 1'b1;
         wr.addr = dg_addr4;
         wr.data = left_eff;
      end else if (step && phase_ff && c4.last_col) begin
         wr.en   = 1'b1;
         wr.addr = c4.col;
         wr.data = inside4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         left_ff  <= 1'b0;
         tc_ff    <= '0;
      end else begin
         if (step) begin
            phase_ff <= !phase_ff && needs2;
         end
         if (retire && grid4) begin
            left_ff <= inside4_ff;
         end
         if (emit && grid4) begin
            tc_ff <= (tc_cur == TRI_MAX) ? tc_cur : tc_cur + SLOT_W'(1);
         end else if (step && !phase_ff && grid4 && c4.restart) begin
            tc_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && !phase_ff) begin
         both_ff <= both;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `FGTC_ASSERT_NOW(a_phase_grid, phase_ff,
      stage_valid_ff[EMIT_STAGE] && (ctrl_ff[EMIT_STAGE].mode == MODE_GRID),
      "second emit phase without a grid vertex")
   `FGTC_ASSERT_NOW(a_restart_slot, emit && grid4 && c4.restart && !phase_ff,
      rsp_next.tri_slot == '0, "restart vertex emits a nonzero triangle slot")
   `FGTC_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_ff), $past(stage_valid_ff[EMIT_STAGE]),
      "response raised without an item in the emit stage")
   `FGTC_ASSERT_NEXT(a_two_cycle_hold, step && !phase_ff && needs2,
      phase_ff && stage_valid_ff[EMIT_STAGE], "two-cycle vertex left the emit stage early")

endmodule

`default_nettype wire

// ===== rtl/fgtc_ram.sv =====
// Generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module fgtc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== dv/culler_checker.sv =====
// Frustum culler checker: predicts sphere answers and culled grid triangles, compares results
`timescale 1ns / 1ps

module culler_checker
   import fgtc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_payload,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);

   localparam int ROW_LAST     = 255;

   logic [CSR_DATA_W-1:0] plane_words [PLANE_COUNT];
   logic [COLS_W-1:0]     grid_cols;
   logic                  row_bits [MAX_COLUMNS];
   logic                  left_bit;
   int unsigned           col_pos;
   int unsigned           row_pos;
   logic [VERT_W-1:0]     next_vertex;
   logic [SLOT_W-1:0]     next_slot;
   rsp_type               expected_rsp_q [$];

   function automatic logic point_inside(req_type r, logic [RAD_W-1:0] rad);
      longint x, y, z, a, b, c, d, distance, lim;
      int p;
      x = $signed(r.pos_x);
      y = $signed(r.pos_y);
      z = $signed(r.pos_z);
      lim = longint'(rad) <<< FRAC_SHIFT;
      for (p = 0; p < PLANE_COUNT; p++) begin
         a = $signed(plane_words[p][15:0]);
         b = $signed(plane_words[p][31:16]);
         c = $signed(plane_words[p][47:32]);
         d = $signed(plane_words[p][63:48]);
         distance = a * x + b * y + c * z + (d <<< FRAC_SHIFT);
         if (distance > lim) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type make_triangle(logic [VERT_W-1:0] ca, logic [VERT_W-1:0] cb,
                                             logic [VERT_W-1:0] cc);
      rsp_type t;
      t = '0;
      t.result_kind = KIND_TRIANGLE;
      t.tri_slot = next_slot;
      t.corner_a = ca;
      t.corner_b = cb;
      t.corner_c = cc;
      if (next_slot != TRI_MAX) next_slot = next_slot + 1'b1;
      return t;
   endfunction

   task automatic predict_vertex(input req_type r);
      int unsigned cols, c;
      logic [VERT_W-1:0] v, u;
      logic cur, up, diag;
      rsp_type made [2];
      int n, k;
      if (r.restart) begin
         col_pos = 0;
         row_pos = 0;
         next_vertex = '0;
         next_slot = '0;
         left_bit = 1'b0;
      end
      cols = grid_cols;
      if (cols < COLS_MIN) cols = COLS_MIN;
      if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
      c = (col_pos >= cols) ? cols - 1 : col_pos;
      v = next_vertex;
      u = v - VERT_W'(cols);
      cur = point_inside(r, '0);
      n = 0;
      if (c > 0) begin
         up = row_bits[c];
         diag = row_bits[c - 1];
         if (row_pos > 0) begin
            if (left_bit | cur | up) begin
               made[n] = make_triangle(v - 1'b1, v, u);
               n++;
            end
            if (left_bit | up | diag) begin
               made[n] = make_triangle(v - 1'b1, u, u - 1'b1);
               n++;
            end
         end
         row_bits[c - 1] = left_bit;
      end
      if (c == cols - 1) row_bits[c] = cur;
      left_bit = cur;
      for (k = 0; k < n; k++) begin
         if (k == n - 1) made[k].last = 1'b1;
         expected_rsp_q.push_back(made[k]);
      end
      if (c + 1 >= cols) begin
         col_pos = 0;
         if (row_pos < ROW_LAST) row_pos++;
      end else begin
         col_pos = c + 1;
      end
      if (next_vertex != VERTEX_MAX) next_vertex = next_vertex + 1'b1;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type answer;
      int i;
      if (reset) begin
         for (i = 0; i < PLANE_COUNT; i++) plane_words[i] = '0;
         for (i = 0; i < MAX_COLUMNS; i++) row_bits[i] = 1'b0;
         grid_cols = GRID_COLUMNS_RESET;
         left_bit = 1'b0;
         col_pos = 0;
         row_pos = 0;
         next_vertex = '0;
         next_slot = '0;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, got %h", $time, rsp_payload);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload !== want) begin
                  fail_count++;
                  $display("%0t: result mismatch: expected %h, got %h",
                           $time, want, rsp_payload);
               end
            end
         end
         if (csr_wen) begin
            if (csr_index < PLANE_COUNT) plane_words[csr_index] = csr_wdata;
            else if (csr_index == CSR_GRID_COLUMNS) grid_cols = csr_wdata[COLS_W-1:0];
         end
         if (req_valid && !req_stall) begin
            if (req_payload.mode == MODE_SPHERE) begin
               answer = '0;
               answer.result_kind = KIND_SPHERE;
               answer.inside_res = point_inside(req_payload, req_payload.radius);
               answer.last = 1'b1;
               expected_rsp_q.push_back(answer);
            end else begin
               predict_vertex(req_payload);
            end
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Top of the frustum culler testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import fgtc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int COEF_ONE       = 16384;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 100;
   localparam int SWEEP_VERTICES = 520;
   localparam int DRAIN_CYCLES   = 12;
   localparam int HOLD_CYCLES    = 300;
   localparam int FULL_SPAN      = 32767;
   localparam logic [13:0] DIRECTED_INSIDE = 14'b11_000000_100001;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_wen     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;
   logic                   hold_rsp    = 1'b0;
   logic                   sweeping    = 1'b0;
   int                     fail_count;
   int                     outstanding;

   frustum_grid_triangle_culler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   culler_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver: stall pattern changes at random intervals, long hold on request
   initial begin : receiver
      int style;
      int style_left;
      logic held;
      style = 0;
      style_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !held) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end else begin
            if (style_left == 0) begin
               style = sweeping ? $urandom_range(0, 1) : $urandom_range(0, 4);
               style_left = $urandom_range(16, 200);
            end
            style_left--;
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 7) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               3: rsp_stall <= (style_left % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   function automatic logic [CSR_DATA_W-1:0] plane_word(int a, int b, int c, int d);
      return {16'(d), 16'(c), 16'(b), 16'(a)};
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord(int span);
      if ($urandom_range(0, 9) == 0) return COORD_W'($urandom);
      return COORD_W'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic req_type make_req(mode_type m, logic rs, int x, int y, int z, int rad);
      req_type r;
      r.mode = m;
      r.restart = rs;
      r.pos_x = COORD_W'(x);
      r.pos_y = COORD_W'(y);
      r.pos_z = COORD_W'(z);
      r.radius = RAD_W'(rad);
      return r;
   endfunction

   function automatic req_type random_request(int span, logic first, logic grid_only);
      req_type r;
      r.mode = MODE_GRID;
      r.restart = first;
      r.pos_x = rand_coord(span);
      r.pos_y = rand_coord(span);
      r.pos_z = rand_coord(span);
      r.radius = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 512));
      if (!first && !grid_only) begin
         if ($urandom_range(0, 99) < 15) begin
            r.mode = MODE_SPHERE;
            r.restart = 1'($urandom_range(0, 1));
         end else begin
            r.restart = ($urandom_range(0, 99) == 0);
         end
      end
      return r;
   endfunction

   task automatic send_item(input req_type item);
      @(negedge clock);
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic load_box(input int half);
      write_reg(CSR_PLANE_TOP,    plane_word(0, COEF_ONE, 0, -half));
      write_reg(CSR_PLANE_BOTTOM, plane_word(0, -COEF_ONE, 0, half));
      write_reg(CSR_PLANE_RIGHT,  plane_word(COEF_ONE, 0, 0, -half));
      write_reg(CSR_PLANE_LEFT,   plane_word(-COEF_ONE, 0, 0, half));
      write_reg(CSR_PLANE_FAR,    plane_word(0, 0, COEF_ONE, -half));
      write_reg(CSR_PLANE_NEAR,   plane_word(0, 0, -COEF_ONE, half));
   endtask

   task automatic load_same_planes(input logic [CSR_DATA_W-1:0] word);
      int i;
      for (i = 0; i < PLANE_COUNT; i++) write_reg(CSR_INDEX_W'(i), word);
   endtask

   initial begin : stimulus
      int ph, i, k, sent, burst, half, span, cols;
      logic fresh;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // planes at reset: everything inside
      send_item(make_req(MODE_SPHERE, 1'b1, -32768, -32768, -32768, 0));
      send_item(make_req(MODE_SPHERE, 1'b0, 32767, 32767, 32767, 32767));
      send_item(make_req(MODE_GRID, 1'b0, -32768, 32767, -32768, 32767));
      drain();

      load_box(1024);
      write_reg(CSR_GRID_COLUMNS, CSR_DATA_W'(2));
      send_item(make_req(MODE_SPHERE, 1'b0, 0, 1124, 0, 100));
      send_item(make_req(MODE_SPHERE, 1'b0, 0, 1125, 0, 100));
      send_item(make_req(MODE_SPHERE, 1'b0, 1024, 1024, -1024, 0));
      for (i = 0; i < 14; i++)
         send_item(make_req(MODE_GRID, i == 0, 0, DIRECTED_INSIDE[i] ? 0 : 2048, 0, 0));
      drain();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            2, 5: begin
               for (i = 0; i < PLANE_COUNT; i++)
                  write_reg(CSR_INDEX_W'(i), {$urandom, $urandom});
               span = FULL_SPAN;
            end
            3: begin
               load_same_planes(64'h8000_8000_8000_8000);
               span = FULL_SPAN;
            end
            7: begin
               load_same_planes(64'h7FFF_7FFF_7FFF_7FFF);
               span = FULL_SPAN;
            end
            9: begin
               load_same_planes('0);
               span = FULL_SPAN;
            end
            default: begin
               half = $urandom_range(64, 12000);
               load_box(half);
               span = half + half / 2;
            end
         endcase
         case (ph)
            0: cols = 3;
            1: cols = 2;
            2: cols = $urandom_range(4, 16);
            3: cols = 0;
            4: cols = 1;
            5: cols = $urandom_range(257, 511);
            6: cols = $urandom_range(2, 40);
            7: cols = 129;
            8: cols = 256;
            default: cols = 5;
         endcase
         write_reg(CSR_GRID_COLUMNS, CSR_DATA_W'(cols));
         if (ph == 0) write_reg(CSR_UNUSED_INDEX, {$urandom, $urandom});
         fresh = (ph != 3 && ph != 6);
         if (ph == 1) hold_rsp = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
               send_item(random_request(span, fresh, 1'b0));
               fresh = 1'b0;
               sent++;
            end
            if (!hold_rsp) begin
               if ($urandom_range(0, 29) == 0) drain();
               else if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
            end
         end
         drain();
         hold_rsp = 1'b0;
      end

      // long narrow grid with every vertex inside: the row counter saturates
      load_same_planes('0);
      write_reg(CSR_GRID_COLUMNS, CSR_DATA_W'(COLS_MIN));
      sweeping = 1'b1;
      for (k = 0; k < SWEEP_VERTICES; k++)
         send_item(random_request(FULL_SPAN, k == 0, 1'b1));
      sweeping = 1'b0;
      drain();

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
